/* src/ema_pkg.sv */
// ----------------------------------------------------------------------------
// ema_pkg: shared constants and types for the exp(-x) approximation
// Fixed-point formats, polynomial coefficients and pipeline sizing.
// ----------------------------------------------------------------------------
package ema_pkg;

	// port field widths
	localparam int unsigned X_W   = 24;
	localparam int unsigned EXP_W = 25;

	// number formats of the argument and of the result
	localparam int unsigned IN_FRAC_BITS  = 16;
	localparam int unsigned OUT_FRAC_BITS = 24;

	// polynomial arithmetic in unsigned Q28
	localparam int unsigned POLY_FRAC = 28;
	localparam int unsigned XQ_W      = 32;
	localparam int unsigned ACC_W     = 31;
	localparam int unsigned PROD_W    = XQ_W + ACC_W;

	// argument limit 13.0, compared with four spare integer bits
	localparam int unsigned LIM_W = X_W + 4;
	localparam logic [LIM_W-1:0] X_LIMIT = LIM_W'(13) << IN_FRAC_BITS;

	// mantissa, square, exponent and quotient widths
	localparam int unsigned M_W  = 32;
	localparam int unsigned SQ_W = 2 * M_W;
	localparam int unsigned E_W  = 10;
	localparam int unsigned Q_W  = M_W + 1;
	localparam int unsigned S_W  = E_W + 2;

	// long division: one quotient bit per step, two steps per stage
	localparam int unsigned DIV_STEPS     = Q_W;
	localparam int unsigned DIV_PER_STAGE = 2;
	localparam int unsigned DIV_STAGES    = (DIV_STEPS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

	// stage bookkeeping: input, horner, normalise, three squarings, division
	localparam int unsigned HORNER_STEPS = 4;
	localparam int unsigned SQ_STEPS     = 3;
	localparam int unsigned ST_NORM      = 2 + 2 * HORNER_STEPS;
	localparam int unsigned ST_SQ_END    = ST_NORM + 2 * SQ_STEPS;
	localparam int unsigned NS           = ST_SQ_END + DIV_STAGES;

	typedef logic [M_W-1:0]         mant_t;
	typedef logic signed [E_W-1:0]  expo_t;

	// taylor coefficients of exp(x/8) in Q28
	localparam logic [ACC_W-1:0] COEF_A0 = ACC_W'(1) << 28;
	localparam logic [ACC_W-1:0] COEF_A1 = ACC_W'(1) << 25;
	localparam logic [ACC_W-1:0] COEF_A2 = ACC_W'(1) << 21;
	localparam logic [ACC_W-1:0] COEF_A3 = ACC_W'(87381);
	localparam logic [ACC_W-1:0] COEF_A4 = ACC_W'(2731);

	function automatic logic [ACC_W-1:0] poly_coef(input int unsigned k);
		logic [ACC_W-1:0] c;
		case (k)
			0: c = COEF_A0;
			1: c = COEF_A1;
			2: c = COEF_A2;
			3: c = COEF_A3;
			4: c = COEF_A4;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* src/exp_minus_approx.sv */
// ----------------------------------------------------------------------------
// exp_minus_approx: pipelined approximation of exp(-x)
// (1 + x/8 + x^2/128 + x^3/3072 + x^4/98304)^-8 in fixed point.
// ----------------------------------------------------------------------------
// Usage
//   sample channel: x_value (unsigned, 16 fraction bits) with sample_valid and
//   sample_stall. A transfer happens on a clock edge with valid high and stall
//   low.
//   result channel: exp_value (unsigned, 24 fraction bits, 1.0 = 2^24) with
//   result_valid and result_stall. Arguments of 13.0 or more give 0.
//   Throughput: one sample per cycle while sample_stall is low. Pipeline:
//   1 input stage, 8 horner stages (multiply and add per coefficient),
//   1 normalise stage, 6 squaring stages and 17 long-division stages at two
//   quotient bits each (one in the last); rounding feeds the output register.
//   When result_stall holds a result, the pipeline keeps running into a
//   one-entry skid register; only once that is occupied does sample_stall
//   rise, and the whole pipeline holds until the skid drains.
//   Reset (arst_n low) empties the pipeline, the output and the skid register;
//   no result is pending afterwards.
// ----------------------------------------------------------------------------
module exp_minus_approx (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [ema_pkg::X_W-1:0]   x_value,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [ema_pkg::EXP_W-1:0] exp_value
);
	import ema_pkg::*;

	// pipeline control
	logic          en;
	logic [NS:1]   vld_s;
	logic [NS:1]   big_s;
	logic          big_in;

	// horner section, indexed by step
	logic [XQ_W-1:0]   xq_s [1:ST_NORM-3];
	logic [PROD_W-1:0] hp_s [HORNER_STEPS];
	logic [ACC_W-1:0]  ha_s [HORNER_STEPS];

	// normalised polynomial value
	mant_t m_s10;
	expo_t e_s10;

	// squarings, indexed by step
	logic [SQ_W-1:0] sq_p_s  [SQ_STEPS];
	expo_t           sq_pe_s [SQ_STEPS];
	mant_t           sq_m_s  [SQ_STEPS];
	expo_t           sq_e_s  [SQ_STEPS];

	// division, indexed by stage
	mant_t          div_rem_s [DIV_STAGES];
	logic [Q_W-1:0] div_quo_s [DIV_STAGES];
	mant_t          div_m_s   [DIV_STAGES];
	expo_t          div_e_s   [DIV_STAGES];

	// output side
	logic             pipe_out;
	logic [EXP_W-1:0] res;
	logic [EXP_W-1:0] exp_q;
	logic [EXP_W-1:0] skid_q;
	logic             out_vld_q;
	logic             skid_vld_q;

	assign en           = !skid_vld_q;
	assign sample_stall = skid_vld_q;
	assign result_valid = out_vld_q;
	assign exp_value    = exp_q;

	assign big_in = {4'b0, x_value} >= X_LIMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NS-1:1], sample_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			big_s    <= {big_s[NS-1:1], big_in};
			xq_s[1]  <= XQ_W'(x_value) << (POLY_FRAC - IN_FRAC_BITS);
			for (int st = 2; st <= ST_NORM - 3; st++) begin
				xq_s[st] <= xq_s[st-1];
			end
		end
	end

	// horner: multiply stage then round-and-add stage per coefficient
	for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
		logic [ACC_W-1:0]  acc_in;
		logic [PROD_W-1:0] rsum;

		if (i == 0) begin : g_first
			assign acc_in = poly_coef(HORNER_STEPS);
		end else begin : g_rest
			assign acc_in = ha_s[i-1];
		end

		assign rsum = hp_s[i] + (PROD_W'(1) << (POLY_FRAC - 1));

		always_ff @(posedge clk) begin
			if (en) begin
				hp_s[i] <= PROD_W'(xq_s[1+2*i]) * PROD_W'(acc_in);
				ha_s[i] <= ACC_W'(PROD_W'(poly_coef(HORNER_STEPS - 1 - i)) + (rsum >> POLY_FRAC));
			end
		end
	end

	// value lies in [2^28, 2^31): shift its leading one up to bit 31
	always_ff @(posedge clk) begin
		if (en) begin
			if (ha_s[HORNER_STEPS-1][ACC_W-1]) begin
				m_s10 <= M_W'(ha_s[HORNER_STEPS-1]) << 1;
				e_s10 <= expo_t'(-(int'(POLY_FRAC) + 1));
			end else if (ha_s[HORNER_STEPS-1][ACC_W-2]) begin
				m_s10 <= M_W'(ha_s[HORNER_STEPS-1]) << 2;
				e_s10 <= expo_t'(-(int'(POLY_FRAC) + 2));
			end else begin
				m_s10 <= M_W'(ha_s[HORNER_STEPS-1]) << 3;
				e_s10 <= expo_t'(-(int'(POLY_FRAC) + 3));
			end
		end
	end

	// three squarings, each a multiply stage and a round/normalise stage
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_square
		mant_t           m_in;
		expo_t           e_in;
		logic [SQ_W:0]   psum;
		logic [M_W:0]    v;
		expo_t           e_nxt;

		if (j == 0) begin : g_first
			assign m_in = m_s10;
			assign e_in = e_s10;
		end else begin : g_rest
			assign m_in = sq_m_s[j-1];
			assign e_in = sq_e_s[j-1];
		end

		// round half up on the dropped bits, 31 or 32 of them
		always_comb begin
			if (sq_p_s[j][SQ_W-1]) begin
				psum = {1'b0, sq_p_s[j]} + ((SQ_W+1)'(1) << (M_W - 1));
				v    = psum[SQ_W:M_W];
			end else begin
				psum = {1'b0, sq_p_s[j]} + ((SQ_W+1)'(1) << (M_W - 2));
				v    = psum[SQ_W-1:M_W-1];
			end
			e_nxt = expo_t'(sq_pe_s[j] + sq_pe_s[j]
				+ (sq_p_s[j][SQ_W-1] ? expo_t'(M_W) : expo_t'(M_W - 1))
				+ (v[M_W] ? expo_t'(1) : expo_t'(0)));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_p_s[j]  <= SQ_W'(m_in) * SQ_W'(m_in);
				sq_pe_s[j] <= e_in;
				sq_m_s[j]  <= v[M_W] ? v[M_W:1] : v[M_W-1:0];
				sq_e_s[j]  <= e_nxt;
			end
		end
	end

	// restoring division of 2^63 by the mantissa, quotient msb first
	for (genvar d = 0; d < DIV_STAGES; d++) begin : g_div
		mant_t          m_in;
		expo_t          e_in;
		mant_t          r_in;
		logic [Q_W-1:0] q_in;
		mant_t          r;
		logic [Q_W-1:0] q;
		logic [M_W:0]   t;

		if (d == 0) begin : g_first
			assign m_in = sq_m_s[SQ_STEPS-1];
			assign e_in = sq_e_s[SQ_STEPS-1];
			assign r_in = mant_t'(1) << (M_W - 2);
			assign q_in = '0;
		end else begin : g_rest
			assign m_in = div_m_s[d-1];
			assign e_in = div_e_s[d-1];
			assign r_in = div_rem_s[d-1];
			assign q_in = div_quo_s[d-1];
		end

		always_comb begin
			r = r_in;
			q = q_in;
			t = '0;
			for (int k = 0; k < DIV_PER_STAGE; k++) begin
				if (d * DIV_PER_STAGE + k < DIV_STEPS) begin
					t = {r, 1'b0};
					if (t >= {1'b0, m_in}) begin
						r = M_W'(t - {1'b0, m_in});
						q = {q[Q_W-2:0], 1'b1};
					end else begin
						r = t[M_W-1:0];
						q = {q[Q_W-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_s[d] <= r;
				div_quo_s[d] <= q;
				div_m_s[d]   <= m_in;
				div_e_s[d]   <= e_in;
			end
		end
	end

	// scale the quotient by 2^-s with rounding, s = 63 + e - out fraction bits
	always_comb begin
		logic signed [S_W-1:0] s;
		logic [5:0]            sa;
		logic [Q_W-1:0]        tq;
		logic [Q_W:0]          rs;
		logic [Q_W-1:0]        r;

		s  = S_W'(div_e_s[DIV_STAGES-1]) + S_W'(63 - int'(OUT_FRAC_BITS));
		sa = 6'(s - S_W'(1));
		tq = div_quo_s[DIV_STAGES-1] >> sa;
		rs = {1'b0, tq} + (Q_W+1)'(1);
		if (s <= S_W'(0)) begin
			r = div_quo_s[DIV_STAGES-1];
		end else if (s >= S_W'(64)) begin
			r = '0;
		end else begin
			r = rs[Q_W:1];
		end
		res = big_s[NS] ? '0 : EXP_W'(r);
	end

	assign pipe_out = en && vld_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (!result_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (pipe_out) begin
			if (out_vld_q && result_stall) begin
				skid_vld_q <= 1'b1;
			end else begin
				out_vld_q <= 1'b1;
			end
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!result_stall) begin
				exp_q <= skid_q;
			end
		end else if (pipe_out) begin
			if (out_vld_q && result_stall) begin
				skid_q <= res;
			end else begin
				exp_q <= res;
			end
		end
	end

	// skid register only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid register occupied with no output pending");

	// polynomial stays in [1.0, 8.0) in Q28 for arguments below the limit
	a_poly_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_NORM-1] && !big_s[ST_NORM-1] |->
			ha_s[HORNER_STEPS-1][ACC_W-1 -: 3] != 3'b000)
		else $error("polynomial value out of range");

	// the last squaring leaves a normalised mantissa
	a_mant_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_SQ_END] && !big_s[ST_SQ_END] |-> sq_m_s[SQ_STEPS-1][M_W-1])
		else $error("mantissa not normalised after squaring");

	// quotient never exceeds 2^32
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS] && !big_s[NS] |->
			(!div_quo_s[DIV_STAGES-1][Q_W-1] || div_quo_s[DIV_STAGES-1][Q_W-2:0] == '0))
		else $error("reciprocal quotient out of range");

endmodule

/* dv/exp_minus_approx_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exp_minus_approx_tb: self-checking bench for the exp(-x) approximation
// Drives a short table of boundary arguments, then several hundred random
// ones, under random idle and stall bursts on both channels. Every result is
// compared, in transfer order, against its typed-in value or else a bit-exact
// fixed-point model of the polynomial, three squarings and rounded reciprocal.
// ----------------------------------------------------------------------------
module exp_minus_approx_tb;

	localparam int unsigned XW = ema_pkg::X_W;
	localparam int unsigned EW = ema_pkg::EXP_W;

	localparam int unsigned ARG_FRAC  = 16;
	localparam int unsigned RES_FRAC  = 24;
	localparam int unsigned HORNER_Q  = 28;
	localparam logic [XW-1:0] ARG_LIMIT = XW'(13) << ARG_FRAC;
	localparam logic [EW-1:0] RES_ONE   = EW'(1) << RES_FRAC;

	// taylor coefficients of exp(x/8) in Q28
	localparam logic [63:0] TAY_C0 = 64'd1 << 28;
	localparam logic [63:0] TAY_C1 = 64'd1 << 25;
	localparam logic [63:0] TAY_C2 = 64'd1 << 21;
	localparam logic [63:0] TAY_C3 = 64'd87381;
	localparam logic [63:0] TAY_C4 = 64'd2731;

	localparam int RANDOM_ARGS  = 550;
	localparam int QUIET_TAIL   = 60;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic [63:0]        mant;
		logic signed [31:0] expo;
	} mant_exp_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [EW-1:0] exp_value;
	} exp_due_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic          typed;
		logic [EW-1:0] exp_value;
	} sweep_row_t;

	localparam int SWEEP_ROWS = 21;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [XW-1:0] x_value = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [EW-1:0] exp_value;

	exp_due_t exp_due[$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int hold_left = 0;

	// boundary arguments; results typed in where they are obvious
	sweep_row_t sweep_rows [SWEEP_ROWS] = '{
		'{24'h000000, 1'b1, RES_ONE},
		'{24'h000001, 1'b0, '0},
		'{24'h000100, 1'b0, '0},
		'{24'h001000, 1'b0, '0},
		'{24'h008000, 1'b0, '0},
		'{24'h010000, 1'b0, '0},
		'{24'h020000, 1'b0, '0},
		'{24'h050000, 1'b0, '0},
		'{24'h055555, 1'b0, '0},
		'{24'h07ffff, 1'b0, '0},
		'{24'h0aaaaa, 1'b0, '0},
		'{24'h0c0000, 1'b0, '0},
		'{24'h0cfffe, 1'b0, '0},
		'{24'h0cffff, 1'b0, '0},
		'{24'h0d0000, 1'b1, '0},
		'{24'h0d0001, 1'b1, '0},
		'{24'h555555, 1'b1, '0},
		'{24'haaaaaa, 1'b1, '0},
		'{24'h800000, 1'b1, '0},
		'{24'hffffff, 1'b1, '0},
		'{24'h000000, 1'b1, RES_ONE}
	};

	exp_minus_approx i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.x_value      (x_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.exp_value    (exp_value)
	);

	always #1 clk = ~clk;

	function automatic logic [63:0] horner_step(logic [63:0] xq, logic [63:0] acc,
			logic [63:0] coef);
		return coef + ((xq * acc + (64'd1 << (HORNER_Q - 1))) >> HORNER_Q);
	endfunction

	// mantissa into [2^31, 2^32), rounding half up on a right shift
	function automatic mant_exp_t mant_normalise(logic [63:0] v, int expo);
		mant_exp_t r;
		int top;
		int sh;
		if (v == 0)
			v = 64'd1;
		top = 0;
		for (int n = 0; n < 64; n++)
			if (v[n])
				top = n;
		if (top < 31) begin
			v = v << (31 - top);
			expo = expo - (31 - top);
		end else if (top > 31) begin
			sh = top - 31;
			v = (v + (64'd1 << (sh - 1))) >> sh;
			expo = expo + sh;
			if (v[32]) begin
				v = v >> 1;
				expo = expo + 1;
			end
		end
		r.mant = v;
		r.expo = expo;
		return r;
	endfunction

	function automatic logic [EW-1:0] exp_neg_predict(logic [XW-1:0] x);
		logic [63:0] xq;
		logic [63:0] acc;
		logic [63:0] quot;
		logic [63:0] res;
		mant_exp_t p;
		int s;
		if (x >= ARG_LIMIT)
			return '0;
		xq = 64'(x) << (HORNER_Q - ARG_FRAC);
		acc = TAY_C4;
		acc = horner_step(xq, acc, TAY_C3);
		acc = horner_step(xq, acc, TAY_C2);
		acc = horner_step(xq, acc, TAY_C1);
		acc = horner_step(xq, acc, TAY_C0);
		p = mant_normalise(acc, -int'(HORNER_Q));
		// p^8 by three squarings
		repeat (3)
			p = mant_normalise(p.mant * p.mant, 2 * p.expo);
		quot = (64'd1 << 63) / p.mant;
		s = 63 + p.expo - int'(RES_FRAC);
		if (s <= 0)
			res = quot;
		else if (s >= 64)
			res = '0;
		else
			res = ((quot >> (s - 1)) + 64'd1) >> 1;
		return res[EW-1:0];
	endfunction

	task automatic send_sample(input logic [XW-1:0] x, input logic typed,
			input logic [EW-1:0] typed_exp);
		exp_due_t due;
		if ($urandom_range(0, 99) < idle_pct) begin
			sample_valid <= 1'b0;
			x_value <= XW'($urandom);
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (sample_stall);
		due.x = x;
		due.exp_value = typed ? typed_exp : exp_neg_predict(x);
		exp_due.push_back(due);
	endtask

	// result side: check each transfer, then pick the next stall
	always @(posedge clk) begin
		exp_due_t due;
		if (arst_n && result_valid && !result_stall) begin
			if (exp_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got exp_value=%h",
					$time, exp_value);
			end else begin
				due = exp_due.pop_front();
				if (exp_value !== due.exp_value) begin
					errors++;
					$display("%0t: x_value=%h exp_value expected %h, got %h",
						$time, due.x, due.exp_value, exp_value);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			hold_left = $urandom_range(1, 18) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, exp_due.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		logic [XW-1:0] x;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 20;
		foreach (sweep_rows[i])
			send_sample(sweep_rows[i].x, sweep_rows[i].typed, sweep_rows[i].exp_value);

		for (int n = 0; n < RANDOM_ARGS; n++) begin
			// idling level changes in blocks, with a quiet tail
			if (n >= RANDOM_ARGS - QUIET_TAIL)
				idle_pct = 0;
			else if (n % 50 == 0)
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 25;
					default: idle_pct = 50;
				endcase
			case ($urandom_range(0, 9))
				0: x = XW'($urandom_range(0, 4095));
				1, 2: x = XW'($urandom);
				3: x = ARG_LIMIT - XW'(32) + XW'($urandom_range(0, 63));
				default: x = XW'($urandom_range(0, ARG_LIMIT - 1));
			endcase
			send_sample(x, 1'b0, '0);
		end
		sample_valid <= 1'b0;

		while (exp_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/ema_pkg.sv
src/exp_minus_approx.sv
dv/exp_minus_approx_tb.sv
